// ----- hdl/edt_pkg.sv -----
package edt_pkg;

  // Tone period divider: a fixed 2^20 dividend over a frequency of up to 5000.
  localparam int DIVIDEND_W = 21;
  localparam int DIVISOR_W  = 13;
  localparam logic [DIVIDEND_W-1:0] TONE_CLOCK = 21'd1048576;

  // Result field widths.
  localparam int STAMP_W  = 16;
  localparam int DIST_W   = 11;
  localparam int PERIOD_W = 14;
  localparam int HALF_W   = 13;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Distance zone limits.
  localparam logic [DIST_W-1:0] D_NEAR     = 11'd10;
  localparam logic [DIST_W-1:0] D_RED      = 11'd30;
  localparam logic [DIST_W-1:0] D_FAR      = 11'd50;
  localparam logic [DIST_W-1:0] D_TONE_MIN = 11'd5;

  // Reciprocal of 9 scaled by 2^19, exact for dividends below 74898.
  localparam logic [15:0] RECIP_9 = 16'd58255;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_FREQ,
    ST_START,
    ST_DIV,
    ST_DONE
  } edt_state_t;

  // Status of the period divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } edt_div_stat_t;

  // Tone frequency 1000*k/9 for a curve step k of 0 to 45.
  function automatic logic [DIVISOR_W-1:0] tone_freq(input logic [5:0] k);
    logic [15:0] scaled;
    logic [31:0] prod;
    begin
      scaled = ({10'd0, k} << 10) - ({10'd0, k} << 4) - ({10'd0, k} << 3);
      prod   = {16'd0, scaled} * {16'd0, RECIP_9};
      tone_freq = prod[RECIP_SHIFT +: DIVISOR_W];
    end
  endfunction

endpackage

// ----- hdl/edt_divider.sv -----
module edt_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [edt_pkg::DIVISOR_W-1:0] divisor,
  output edt_pkg::edt_div_stat_t        stat,
  output logic [edt_pkg::DIVIDEND_W-1:0] quotient
);
  import edt_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  div_r, div_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      rem_nxt  = '0;
      quo_nxt  = TONE_CLOCK;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  // Done is the cycle whose step writes the last quotient bit.
  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CNT_W'(1));
  assign quotient  = quo_nxt;

endmodule

// ----- hdl/echo_distance_to_tone.sv -----
// Sequence: a rising capture is absorbed at acceptance; a falling capture steps through
// ST_DIST, ST_FREQ, ST_START, ST_DIV (skipped when the tone is silent) and ST_DONE.
// Input is held off until the result item is loaded, so echo pairs are paced by the 21-step
// restoring divider that computes the tone period.
// Reset (rst_n low, synchronous) expects a rising capture next and clears the
// stored stamp and all handshake state.
module echo_distance_to_tone (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] capture_count, [16] switch_one_closed, [17] switch_two_closed
  input  logic [edt_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [10:0] distance, [11] red_led, [12] green_led, [26:13] tone_period,
  // [39:27] tone_half_period
  output logic [edt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import edt_pkg::*;

  edt_state_t state_r, state_nxt;

  logic                  awaiting_r, awaiting_nxt;
  logic [STAMP_W-1:0]    rise_r, rise_nxt;
  logic [STAMP_W-1:0]    width_r, width_nxt;
  logic                  curve_r, curve_nxt;
  logic [DIST_W-1:0]     dist_r, dist_nxt;
  logic                  red_r, red_nxt;
  logic                  green_r, green_nxt;
  logic [DIVISOR_W-1:0]  freq_r, freq_nxt;
  logic [PERIOD_W-1:0]   period_r, period_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  in_acc;
  logic                  div_start;
  logic                  load_out;
  edt_div_stat_t         div_stat;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [20:0]           width17;
  logic [DIST_W-1:0]     step;
  logic                  in_tone;

  // Period divider.
  edt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (freq_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_acc = in_tvalid && in_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && awaiting_r) begin
          state_nxt = ST_DIST;
        end
      end
      ST_DIST:  state_nxt = ST_FREQ;
      ST_FREQ:  state_nxt = ST_START;
      ST_START: state_nxt = (freq_r == '0) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_START: div_start = (freq_r != '0);
      ST_DONE:  load_out  = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Capture pairing: a rising stamp is kept, a falling one yields the width.
  always_comb begin
    awaiting_nxt = awaiting_r;
    rise_nxt     = rise_r;
    width_nxt    = width_r;
    curve_nxt    = curve_r;
    if (in_acc) begin
      awaiting_nxt = !awaiting_r;
      if (!awaiting_r) begin
        rise_nxt = in_tdata[STAMP_W-1:0];
      end else begin
        width_nxt = in_tdata[STAMP_W-1:0] - rise_r;
        curve_nxt = in_tdata[16] || in_tdata[17];
      end
    end
  end

  // Distance is 17*width/1024; zone flags follow from it.
  assign width17 = {1'b0, width_r, 4'd0} + {5'd0, width_r};

  always_comb begin
    dist_nxt  = dist_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    if (state_r == ST_DIST) begin
      dist_nxt  = width17[20:10];
      red_nxt   = width17[20:10] < D_RED;
      green_nxt = (width17[20:10] < D_NEAR) ||
                  ((width17[20:10] >= D_RED) && (width17[20:10] <= D_FAR));
    end
  end

  // Tone frequency on the selected curve, zero outside the tone band.
  assign in_tone = (dist_r >= D_TONE_MIN) && (dist_r <= D_FAR);
  assign step    = curve_r ? (dist_r - D_TONE_MIN) : (D_FAR - dist_r);

  always_comb begin
    freq_nxt = freq_r;
    if (state_r == ST_FREQ) begin
      freq_nxt = in_tone ? tone_freq(step[5:0]) : '0;
    end
  end

  // Period: silent when the frequency is zero, else the divider quotient.
  always_comb begin
    period_nxt = period_r;
    if (state_r == ST_START && freq_r == '0) begin
      period_nxt = '0;
    end else if (state_r == ST_DIV && div_stat.done) begin
      period_nxt = div_quo[PERIOD_W-1:0];
    end
  end

  // Output register holds the item until the downstream side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {period_r[PERIOD_W-1:1], period_r, green_r, red_r, dist_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      rise_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      rise_r      <= rise_nxt;
      out_valid_r <= out_valid_nxt;
    end
    width_r    <= width_nxt;
    curve_r    <= curve_nxt;
    dist_r     <= dist_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    freq_r     <= freq_nxt;
    period_r   <= period_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == ST_DIV)
    else $error("divider busy outside its wait state");

  // A falling capture starts the distance step next cycle.
  a_fall_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && awaiting_r) |=> state_r == ST_DIST)
    else $error("falling capture did not start the computation");

  // The duty field is always half of the period field.
  a_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:27] == out_tdata[26:14])
    else $error("half period does not match period");

  // A sounding tone only comes from a distance inside the tone band.
  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[26:13] != '0) |->
      (out_tdata[10:0] >= D_TONE_MIN && out_tdata[10:0] <= D_FAR))
    else $error("tone produced outside the tone band");

endmodule
